### rtl/core/rbpi_pkg.sv
// Shared types and constants of the rigid body pose integrator.
`default_nettype none

package rbpi_pkg;

   // Width of every velocity and pose field on the item and result ports.
   localparam int FIELD_W = 32;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Register index of the time step in the configuration space.
   localparam logic CSR_TIME_STEP_IDX = 1'b0;
   localparam logic [31:0] TIME_STEP_RESET = 32'd16777;

   // Angle constants in Q.30 radians.
   localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
   localparam logic [32:0] PI_Q30 = 33'd3373259426;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [33:0] CORDIC_K = 34'd652032874;
   localparam int CORDIC_STEPS = 30;

   // Reciprocal of two pi scaled by 2^23, used to estimate the turn count.
   localparam logic [20:0] TWO_PI_RECIP = 21'((64'd1 << 53) / 64'(TWO_PI_Q30));

   // Arctangent of 2^-i in Q.30 radians.
   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
   };

   // One velocity item as it travels from the front part to the back part.
   typedef struct packed {
      logic signed [FIELD_W-1:0] lin_vel_x;
      logic signed [FIELD_W-1:0] lin_vel_y;
      logic signed [FIELD_W-1:0] lin_vel_z;
      logic signed [FIELD_W-1:0] ang_vel_x;
      logic signed [FIELD_W-1:0] ang_vel_y;
      logic signed [FIELD_W-1:0] ang_vel_z;
      logic                      spin;
   } rbpi_cmd_type;

   // One pose result.
   typedef struct packed {
      logic signed [FIELD_W-1:0] new_pos_x;
      logic signed [FIELD_W-1:0] new_pos_y;
      logic signed [FIELD_W-1:0] new_pos_z;
      logic signed [FIELD_W-1:0] new_quat_w;
      logic signed [FIELD_W-1:0] new_quat_i;
      logic signed [FIELD_W-1:0] new_quat_j;
      logic signed [FIELD_W-1:0] new_quat_k;
   } rbpi_pose_type;

   // Handshake between a producer and a queue.
   typedef struct packed {
      logic valid;
      logic ready;
   } rbpi_link_type;

   // Sign of a partial product of the quaternion product. The term index holds
   // the result component in its upper two bits and the stored component in
   // its lower two bits.
   function automatic logic quat_term_neg(input logic [3:0] term);
      logic neg;
      unique case (term)
         4'd1, 4'd2, 4'd3, 4'd6, 4'd11, 4'd13: neg = 1'b1;
         default: neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

`default_nettype wire

### rtl/core/rbpi_front.sv
// Front part: accepts velocity items and classifies them as spinning or not.
`default_nettype none

module rbpi_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic signed [31:0]         req_lin_vel_x,
   input  wire logic signed [31:0]         req_lin_vel_y,
   input  wire logic signed [31:0]         req_lin_vel_z,
   input  wire logic signed [31:0]         req_ang_vel_x,
   input  wire logic signed [31:0]         req_ang_vel_y,
   input  wire logic signed [31:0]         req_ang_vel_z,
   output rbpi_pkg::rbpi_link_type         link_out,
   input  wire logic                       link_ready,
   output rbpi_pkg::rbpi_cmd_type          cmd_out
);
   import rbpi_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         accept;
   rbpi_cmd_type cmd_ff;
   rbpi_cmd_type cmd_in;

   // The stage is free when empty or when its beat moves on this cycle.
   assign req_full = valid_ff && !link_ready;
   assign accept   = req_push && !req_full;

   // Classify the item: any nonzero angular component means a rotation.
   always_comb begin
      cmd_in.lin_vel_x = req_lin_vel_x;
      cmd_in.lin_vel_y = req_lin_vel_y;
      cmd_in.lin_vel_z = req_lin_vel_z;
      cmd_in.ang_vel_x = req_ang_vel_x;
      cmd_in.ang_vel_y = req_ang_vel_y;
      cmd_in.ang_vel_z = req_ang_vel_z;
      cmd_in.spin      = (|req_ang_vel_x) || (|req_ang_vel_y) || (|req_ang_vel_z);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (link_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign link_out.valid = valid_ff;
   assign link_out.ready = link_ready;
   assign cmd_out        = cmd_ff;

endmodule

`default_nettype wire

### rtl/core/rbpi_queue.sv
// Short command queue between the front and back parts.
`default_nettype none

module rbpi_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  rbpi_pkg::rbpi_link_type    link_in,
   output logic                       link_ready,
   input  rbpi_pkg::rbpi_cmd_type     cmd_in,
   output logic                       cmd_valid,
   input  wire logic                  cmd_pop,
   output rbpi_pkg::rbpi_cmd_type     cmd_out
);
   import rbpi_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rbpi_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign link_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid  = (count_ff != '0);
   assign do_push    = link_in.valid && link_ready;
   assign do_pop     = cmd_pop && cmd_valid;
   assign cmd_out    = entry_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the count tracks occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/rbpi_back.sv
// Back part: position update, speed, sine and cosine, rotation and result register.
`default_nettype none

module rbpi_back #(
   parameter int POS_WIDTH  = 32,
   parameter int QUAT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           time_step,
   input  wire logic                  cmd_valid,
   input  rbpi_pkg::rbpi_cmd_type     cmd_in,
   output logic                       cmd_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output rbpi_pkg::rbpi_pose_type    pose_out
);
   import rbpi_pkg::*;

   // Multiplier operand widths and derived accumulator widths.
   localparam int MA  = (QUAT_WIDTH > 33) ? QUAT_WIDTH : 33;
   localparam int PW  = MA + 33;
   localparam int DW  = PW + 1;
   localparam int QSW = PW - 28;

   localparam logic [6:0] SQRT_LAST   = 7'd31;
   localparam logic [6:0] MOD_LAST    = 7'd1;
   localparam logic [6:0] CORDIC_LAST = 7'(CORDIC_STEPS - 1);
   localparam logic [6:0] DIV_LAST    = 7'd63;
   localparam logic [6:0] QMUL_LAST   = 7'd16;

   typedef enum logic [4:0] {
      ST_IDLE, ST_POS_MUL, ST_POS_ADD, ST_SQ_MUL, ST_SQ_ADD, ST_SQRT,
      ST_HALF_MUL, ST_HALF_LOAD, ST_RECIP_MUL, ST_QUOT_MUL, ST_MOD_LOAD,
      ST_MOD, ST_FOLD, ST_CORDIC, ST_FIX,
      ST_AXIS_MUL, ST_AXIS_LOAD, ST_DIV, ST_SIGN, ST_QSEL, ST_QMUL,
      ST_QSTORE, ST_DONE
   } state_type;

   state_type                     state_ff;
   rbpi_cmd_type                  cmd_ff;
   logic [1:0]                    idx_ff;
   logic [6:0]                    cnt_ff;
   logic [3:0]                    term_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [POS_WIDTH-1:0]   pos_ff [3];
   logic signed [QUAT_WIDTH-1:0]  quat_ff [4];
   logic signed [QSW-1:0]         acc_ff [4];
   logic [63:0]                   sq_ff;
   logic [63:0]                   rad_ff;
   logic [33:0]                   srem_ff;
   logic [31:0]                   root_ff;
   logic [52:0]                   half_ff;
   logic [34:0]                   mrem_ff;
   logic signed [34:0]            r_ff;
   logic signed [33:0]            x_ff;
   logic signed [33:0]            y_ff;
   logic                          neg_both_ff;
   logic                          neg_cos_ff;
   logic signed [31:0]            s_ff;
   logic signed [31:0]            p_ff [4];
   logic [63:0]                   dvd_ff [3];
   logic [31:0]                   drem_ff [3];
   logic                          dneg_ff [3];
   logic                          out_valid_ff;
   rbpi_pose_type                 out_ff;

   logic signed [31:0]            lin_sel;
   logic signed [31:0]            ang_sel;
   logic signed [MA-1:0]          mul_a;
   logic signed [32:0]            mul_b;
   logic signed [PW-1:0]          mul_prod;
   logic signed [PW-1:0]          rnd;
   logic signed [PW-1:0]          d_sh;
   logic signed [DW-1:0]          pos_sum;
   logic signed [POS_WIDTH-1:0]   pos_sat;
   logic [63:0]                   sq_next;
   logic [35:0]                   rem2;
   logic [35:0]                   trial;
   logic [32:0]                   r_fold1;
   logic [32:0]                   r_fold2;
   logic                          fold_nb;
   logic                          fold_nc;
   logic signed [33:0]            cx_dx;
   logic signed [33:0]            cx_dy;
   logic signed [34:0]            c_atan;
   logic signed [33:0]            x_fix;
   logic signed [33:0]            y_fix;
   logic signed [PW-1:0]          prod_mag;
   logic signed [PW-1:0]          term_sh;
   logic signed [QSW-1:0]         term_val;
   logic signed [QUAT_WIDTH-1:0]  quat_sat [4];
   logic                          quat_zero;
   logic                          out_load;

   // Operand selection for the one shared multiplier.
   always_comb begin
      unique case (idx_ff)
         2'd0:    begin lin_sel = cmd_ff.lin_vel_x; ang_sel = cmd_ff.ang_vel_x; end
         2'd1:    begin lin_sel = cmd_ff.lin_vel_y; ang_sel = cmd_ff.ang_vel_y; end
         default: begin lin_sel = cmd_ff.lin_vel_z; ang_sel = cmd_ff.ang_vel_z; end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_POS_MUL: begin
            mul_a = MA'(lin_sel);
            mul_b = $signed({1'b0, time_step});
         end
         ST_SQ_MUL: begin
            mul_a = MA'(ang_sel);
            mul_b = 33'(ang_sel);
         end
         ST_HALF_MUL: begin
            mul_a = $signed(MA'({1'b0, time_step}));
            mul_b = $signed({1'b0, root_ff});
         end
         ST_RECIP_MUL: begin
            mul_a = $signed(MA'({1'b0, half_ff[52:21]}));
            mul_b = $signed(33'(TWO_PI_RECIP));
         end
         ST_QUOT_MUL: begin
            mul_a = $signed(MA'(prod_ff[52:32]));
            mul_b = $signed(HALF_PI_Q30);
         end
         ST_AXIS_MUL: begin
            mul_a = MA'(ang_sel);
            mul_b = 33'(s_ff);
         end
         ST_QMUL: begin
            mul_a = MA'(quat_ff[cnt_ff[1:0]]);
            mul_b = 33'(p_ff[cnt_ff[3:2] ^ cnt_ff[1:0]]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Position step: round the Q24.40 product to Q16.16 and add with saturation.
   assign rnd     = prod_ff + $signed({{(PW - 24){1'b0}}, 1'b1, 23'd0});
   assign d_sh    = rnd >>> 24;
   assign pos_sum = DW'(pos_ff[idx_ff]) + DW'(d_sh);
   always_comb begin
      if ((&pos_sum[DW-1:POS_WIDTH-1]) || !(|pos_sum[DW-1:POS_WIDTH-1])) begin
         pos_sat = pos_sum[POS_WIDTH-1:0];
      end else begin
         pos_sat = {pos_sum[DW-1], {(POS_WIDTH - 1){~pos_sum[DW-1]}}};
      end
   end

   assign sq_next = sq_ff + prod_ff[63:0];

   // One root bit per cycle, two radicand bits at a time.
   assign rem2  = {srem_ff, rad_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};

   // Fold the reduced angle into the first quadrant.
   always_comb begin
      fold_nb = (mrem_ff[32:0] >= PI_Q30);
      r_fold1 = fold_nb ? (mrem_ff[32:0] - PI_Q30) : mrem_ff[32:0];
      fold_nc = (r_fold1 > HALF_PI_Q30);
      r_fold2 = fold_nc ? (PI_Q30 - r_fold1) : r_fold1;
   end

   // Rotation-mode CORDIC step with floor shifts.
   assign cx_dx  = y_ff >>> cnt_ff[4:0];
   assign cx_dy  = x_ff >>> cnt_ff[4:0];
   assign c_atan = $signed({5'd0, ATAN_Q30[cnt_ff[4:0]]});

   always_comb begin
      x_fix = neg_cos_ff ? -x_ff : x_ff;
      y_fix = y_ff;
      if (neg_both_ff) begin
         x_fix = -x_fix;
         y_fix = -y_ff;
      end
   end

   assign prod_mag = prod_ff[PW-1] ? -prod_ff : prod_ff;

   // Partial product of the quaternion product, floor shifted to Q.30.
   assign term_sh  = prod_ff >>> 30;
   assign term_val = term_sh[QSW-1:0];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if ((&acc_ff[k][QSW-1:QUAT_WIDTH-1]) || !(|acc_ff[k][QSW-1:QUAT_WIDTH-1])) begin
            quat_sat[k] = acc_ff[k][QUAT_WIDTH-1:0];
         end else begin
            quat_sat[k] = {acc_ff[k][QSW-1], {(QUAT_WIDTH - 1){~acc_ff[k][QSW-1]}}};
         end
      end
   end

   assign quat_zero = !(|quat_ff[0]) && !(|quat_ff[1]) && !(|quat_ff[2]) && !(|quat_ff[3]);
   assign out_load  = !out_valid_ff || rsp_pop;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;

   // Sequencer with its datapath registers and the result register.
   always_ff @(posedge clock) begin
      prod_ff <= mul_prod;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            quat_ff[k] <= '0;
         end
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd_in;
                  idx_ff   <= '0;
                  sq_ff    <= '0;
                  state_ff <= ST_POS_MUL;
               end
            end
            ST_POS_MUL: begin
               state_ff <= ST_POS_ADD;
            end
            ST_POS_ADD: begin
               pos_ff[idx_ff] <= pos_sat;
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  state_ff <= cmd_ff.spin ? ST_SQ_MUL : ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_POS_MUL;
               end
            end
            ST_SQ_MUL: begin
               state_ff <= ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
               sq_ff <= sq_next;
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  rad_ff   <= sq_next;
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_SQ_MUL;
               end
            end
            ST_SQRT: begin
               rad_ff <= {rad_ff[61:0], 2'b00};
               if (rem2 >= trial) begin
                  srem_ff <= 34'(rem2 - trial);
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  srem_ff <= rem2[33:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == SQRT_LAST) begin
                  state_ff <= ST_HALF_MUL;
               end
            end
            ST_HALF_MUL: begin
               state_ff <= ST_HALF_LOAD;
            end
            ST_HALF_LOAD: begin
               half_ff  <= prod_ff[63:11];
               state_ff <= ST_RECIP_MUL;
            end
            // The turn count is estimated by a reciprocal multiply; it falls
            // short by at most two, so two conditional subtractions finish it.
            ST_RECIP_MUL: begin
               state_ff <= ST_QUOT_MUL;
            end
            ST_QUOT_MUL: begin
               state_ff <= ST_MOD_LOAD;
            end
            ST_MOD_LOAD: begin
               mrem_ff  <= 35'({2'b00, half_ff} - {prod_ff[52:0], 2'b00});
               cnt_ff   <= '0;
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               if (mrem_ff >= 35'(TWO_PI_Q30)) begin
                  mrem_ff <= mrem_ff - 35'(TWO_PI_Q30);
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == MOD_LAST) begin
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               r_ff        <= $signed({2'b00, r_fold2});
               neg_both_ff <= fold_nb;
               neg_cos_ff  <= fold_nc;
               x_ff        <= $signed(CORDIC_K);
               y_ff        <= '0;
               cnt_ff      <= '0;
               state_ff    <= ST_CORDIC;
            end
            ST_CORDIC: begin
               if (!r_ff[34]) begin
                  x_ff <= x_ff - cx_dx;
                  y_ff <= y_ff + cx_dy;
                  r_ff <= r_ff - c_atan;
               end else begin
                  x_ff <= x_ff + cx_dx;
                  y_ff <= y_ff - cx_dy;
                  r_ff <= r_ff + c_atan;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CORDIC_LAST) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               p_ff[0]  <= x_fix[31:0];
               s_ff     <= y_fix[31:0];
               idx_ff   <= '0;
               state_ff <= ST_AXIS_MUL;
            end
            ST_AXIS_MUL: begin
               state_ff <= ST_AXIS_LOAD;
            end
            ST_AXIS_LOAD: begin
               dvd_ff[idx_ff]  <= prod_mag[63:0];
               dneg_ff[idx_ff] <= prod_ff[PW-1];
               drem_ff[idx_ff] <= '0;
               cnt_ff          <= '0;
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_AXIS_MUL;
               end
            end
            ST_DIV: begin
               // Three restoring dividers share the speed as divisor.
               for (int k = 0; k < 3; k++) begin
                  if ({drem_ff[k], dvd_ff[k][63]} >= {1'b0, root_ff}) begin
                     drem_ff[k] <= 32'({drem_ff[k], dvd_ff[k][63]} - {1'b0, root_ff});
                     dvd_ff[k]  <= {dvd_ff[k][62:0], 1'b1};
                  end else begin
                     drem_ff[k] <= {drem_ff[k][30:0], dvd_ff[k][63]};
                     dvd_ff[k]  <= {dvd_ff[k][62:0], 1'b0};
                  end
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               for (int k = 0; k < 3; k++) begin
                  p_ff[k + 1] <= dneg_ff[k] ? -$signed(dvd_ff[k][31:0])
                                            : $signed(dvd_ff[k][31:0]);
               end
               state_ff <= ST_QSEL;
            end
            ST_QSEL: begin
               // An unset orientation takes the rotation as it is.
               cnt_ff <= '0;
               for (int k = 0; k < 4; k++) begin
                  acc_ff[k] <= quat_zero ? QSW'(p_ff[k]) : '0;
               end
               state_ff <= quat_zero ? ST_QSTORE : ST_QMUL;
            end
            ST_QMUL: begin
               term_ff <= cnt_ff[3:0];
               if (cnt_ff != '0) begin
                  if (quat_term_neg(term_ff)) begin
                     acc_ff[term_ff[3:2]] <= acc_ff[term_ff[3:2]] - term_val;
                  end else begin
                     acc_ff[term_ff[3:2]] <= acc_ff[term_ff[3:2]] + term_val;
                  end
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == QMUL_LAST) begin
                  state_ff <= ST_QSTORE;
               end
            end
            ST_QSTORE: begin
               for (int k = 0; k < 4; k++) begin
                  quat_ff[k] <= quat_sat[k];
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_load) begin
                  out_ff.new_pos_x  <= 32'(pos_ff[0]);
                  out_ff.new_pos_y  <= 32'(pos_ff[1]);
                  out_ff.new_pos_z  <= 32'(pos_ff[2]);
                  out_ff.new_quat_w <= 32'(quat_ff[0]);
                  out_ff.new_quat_i <= 32'(quat_ff[1]);
                  out_ff.new_quat_j <= 32'(quat_ff[2]);
                  out_ff.new_quat_k <= 32'(quat_ff[3]);
                  out_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign pose_out  = out_ff;

   // A waiting result is never dropped before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff)
      else $error("waiting result lost");

   // A command leaves the queue only to start the position step.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ST_POS_MUL))
      else $error("command popped outside idle");

   // Only a nonzero angular speed reaches the dividers.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (root_ff != '0))
      else $error("zero divisor in axis division");

   // The reduced angle is below two pi before it is folded.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (mrem_ff < TWO_PI_Q30))
      else $error("angle remainder out of range");

   // The CORDIC counter never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (cnt_ff <= CORDIC_LAST))
      else $error("CORDIC step out of range");

endmodule

`default_nettype wire

### rtl/core/rigid_body_pose_integrator_unit.sv
// Top level of the rigid body pose integrator with its configuration register.
//
//   Channel   Direction  Handshake           Beat
//   req_      in         req_push / req_full  linear and angular velocity
//   rsp_      out        rsp_pop / rsp_empty  position and orientation
//   csr_      in/out     APB psel / penable   time step, Q8.24 seconds
//
// An item without rotation takes only the position steps in the back part; a
// spinning item also takes the 64-step axis division, the 32-step square root,
// the 30 CORDIC steps and the 16 quaternion terms on one multiplier.
// Reset is synchronous, clears the pose and the queues and restores the time step.
// Up to three items wait in front of the back part; a finished result waits
// in its own register while the next item is worked on.
`default_nettype none

module rigid_body_pose_integrator_unit #(
   parameter int POS_WIDTH  = 32,
   parameter int QUAT_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_lin_vel_x,
   input  wire logic signed [31:0] req_lin_vel_y,
   input  wire logic signed [31:0] req_lin_vel_z,
   input  wire logic signed [31:0] req_ang_vel_x,
   input  wire logic signed [31:0] req_ang_vel_y,
   input  wire logic signed [31:0] req_ang_vel_z,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_new_pos_x,
   output logic signed [31:0]      rsp_new_pos_y,
   output logic signed [31:0]      rsp_new_pos_z,
   output logic signed [31:0]      rsp_new_quat_w,
   output logic signed [31:0]      rsp_new_quat_i,
   output logic signed [31:0]      rsp_new_quat_j,
   output logic signed [31:0]      rsp_new_quat_k,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import rbpi_pkg::*;

   logic [31:0]   time_step_ff;
   logic          csr_write;
   rbpi_link_type front_link;
   logic          queue_ready;
   rbpi_cmd_type  front_cmd;
   rbpi_cmd_type  queue_cmd;
   logic          queue_valid;
   logic          queue_pop;
   rbpi_pose_type pose;

   // Configuration register; writes beyond the time step are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_TIME_STEP_IDX) ? time_step_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_TIME_STEP_IDX)) begin
         time_step_ff <= csr_pwdata;
      end
   end

   rbpi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_lin_vel_x (req_lin_vel_x),
      .req_lin_vel_y (req_lin_vel_y),
      .req_lin_vel_z (req_lin_vel_z),
      .req_ang_vel_x (req_ang_vel_x),
      .req_ang_vel_y (req_ang_vel_y),
      .req_ang_vel_z (req_ang_vel_z),
      .link_out      (front_link),
      .link_ready    (queue_ready),
      .cmd_out       (front_cmd)
   );

   rbpi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .link_in    (front_link),
      .link_ready (queue_ready),
      .cmd_in     (front_cmd),
      .cmd_valid  (queue_valid),
      .cmd_pop    (queue_pop),
      .cmd_out    (queue_cmd)
   );

   rbpi_back #(
      .POS_WIDTH  (POS_WIDTH),
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .time_step (time_step_ff),
      .cmd_valid (queue_valid),
      .cmd_in    (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .pose_out  (pose)
   );

   assign rsp_new_pos_x  = pose.new_pos_x;
   assign rsp_new_pos_y  = pose.new_pos_y;
   assign rsp_new_pos_z  = pose.new_pos_z;
   assign rsp_new_quat_w = pose.new_quat_w;
   assign rsp_new_quat_i = pose.new_quat_i;
   assign rsp_new_quat_j = pose.new_quat_j;
   assign rsp_new_quat_k = pose.new_quat_k;

endmodule

`default_nettype wire
